@@ hw/rtl/multimeter_adc_to_reading_defines.svh @@
// ----------------------------------------------------------------------------
// Multimeter ADC-to-reading defines
// Assertion macros used by the file that checks the conversion pipeline.
// ----------------------------------------------------------------------------
`ifndef MULTIMETER_ADC_TO_READING_DEFINES_SVH
`define MULTIMETER_ADC_TO_READING_DEFINES_SVH

// Check cons in the same cycle as ante, clocked on i_clk, off during reset.
`define MAR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define MAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mar_pkg.sv @@
// ----------------------------------------------------------------------------
// mar_pkg
// Types, widths, codes and calibration tables of the ADC-to-reading pipeline.
// ----------------------------------------------------------------------------
package mar_pkg;

    localparam int ADC_FULL_SCALE = 1024;
    localparam int FRAC_BITS      = 16;

    localparam int SAMPLE_W   = 10;
    localparam int READ_W     = 32;
    localparam int QUANT_W    = 2;
    localparam int RANGE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int RI_W       = 2;
    localparam int X_W        = SAMPLE_W + 1;
    localparam int CONST_W    = 27;
    localparam int NUM_W      = 38;
    localparam int MAG_W      = NUM_W - 1;
    localparam int DEN_W      = 36;
    localparam int QUO_W      = 32;
    localparam int SHIFT_IN   = QUO_W - FRAC_BITS - 1;

    localparam int FRONT_STAGES = 3;
    localparam int ROUND_STAGES = 2;
    localparam int PIPE_LAT     = FRONT_STAGES + QUO_W + ROUND_STAGES;

    localparam longint CAL_SCALE = 10000000;
    localparam longint X_SCALE   = 5 * CAL_SCALE;

    // 999.99 at FRAC_BITS, rounded half away from zero
    localparam longint OVER_Q = (longint'(99999) << (FRAC_BITS + 1)) / 100;
    localparam logic [READ_W-1:0] OVER_READ = READ_W'((OVER_Q + 1) >>> 1);

    localparam logic [READ_W-1:0] READ_MAX = {1'b0, {(READ_W-1){1'b1}}};
    localparam logic [READ_W-1:0] READ_MIN = {1'b1, {(READ_W-1){1'b0}}};

    // window limits on the main sample
    localparam logic [SAMPLE_W-1:0] V_OVER_HI = 10'd1003;
    localparam logic [SAMPLE_W-1:0] V_OVER_LO = 10'd206;
    localparam logic [SAMPLE_W-1:0] V_ZERO_LO = 10'd518;
    localparam logic [SAMPLE_W-1:0] V_ZERO_HI = 10'd524;
    localparam logic [SAMPLE_W-1:0] A_OVER_HI = 10'd810;
    localparam logic [SAMPLE_W-1:0] A_OVER_LO = 10'd200;
    localparam logic [SAMPLE_W-1:0] A_ZERO_LO = 10'd406;
    localparam logic [SAMPLE_W-1:0] A_ZERO_HI = 10'd414;
    localparam logic [X_W-1:0]      AC_GAP    = 11'd2;

    localparam logic [QUANT_W-1:0] Q_VOLT = 2'd0;
    localparam logic [QUANT_W-1:0] Q_AMP  = 2'd1;
    localparam logic [QUANT_W-1:0] Q_OHM  = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_LO     = 3'd1;
    localparam logic [RANGE_W-1:0] RANGE_HI_VI  = 3'd4;
    localparam logic [RANGE_W-1:0] RANGE_HI_OHM = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVER = 2'd1,
        ST_ZERO = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [QUANT_W-1:0] quantity;
        logic [RANGE_W-1:0] meter_range;
        logic               coupling;
    } t_cfg;

    localparam t_cfg CFG_RST = '{quantity: Q_VOLT, meter_range: RANGE_LO, coupling: 1'b0};

    // status and sign that ride beside the division
    typedef struct packed {
        t_status status;
        logic    neg;
    } t_side;

    // slope of the calibration line, scaled by CAL_SCALE
    function automatic logic [CONST_W-1:0] cal_slope(input logic amp, input logic [RI_W-1:0] ri);
        logic [CONST_W-1:0] v;
        unique case ({amp, ri})
            3'b000:  v = 27'd59840000;
            3'b001:  v = 27'd5988400;
            3'b010:  v = 27'd587325;
            3'b011:  v = 27'd47988;
            3'b100:  v = 27'd8685700;
            3'b101:  v = 27'd900000;
            3'b110:  v = 27'd124000;
            default: v = 27'd25170000;
        endcase
        return v;
    endfunction

    // intercept of the calibration line, scaled by CAL_SCALE
    function automatic logic [CONST_W-1:0] cal_icpt(input logic amp, input logic [RI_W-1:0] ri);
        logic [CONST_W-1:0] v;
        unique case ({amp, ri})
            3'b000:  v = 27'd24785900;
            3'b001:  v = 27'd25418000;
            3'b010:  v = 27'd25144325;
            3'b011:  v = 27'd25452460;
            3'b100:  v = 27'd22630000;
            3'b101:  v = 27'd23100000;
            3'b110:  v = 27'd20100000;
            default: v = 27'd20120000;
        endcase
        return v;
    endfunction

    // AC voltage offset added to total minus sample
    function automatic logic [SAMPLE_W-1:0] volt_ofs(input logic [RI_W-1:0] ri);
        logic [SAMPLE_W-1:0] v;
        unique case (ri)
            2'd0:    v = 10'd506;
            2'd1:    v = 10'd520;
            2'd2:    v = 10'd516;
            default: v = 10'd522;
        endcase
        return v;
    endfunction

    // divider resistor, scaled by CAL_SCALE; the fourth code is never valid
    function automatic logic [CONST_W-1:0] ohm_div(input logic [RI_W-1:0] ri);
        logic [CONST_W-1:0] v;
        unique case (ri)
            2'd0:    v = 27'd4500000;
            2'd1:    v = 27'd13500000;
            2'd2:    v = 27'd100000000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/mar_front.sv @@
// ----------------------------------------------------------------------------
// mar_front
// Window checks, operand select and numerator/denominator build; 3 stages.
// ----------------------------------------------------------------------------
module mar_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [mar_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [mar_pkg::SAMPLE_W-1:0]    i_total_sample,
    input  mar_pkg::t_cfg                   i_cfg,
    output logic                            o_valid,
    output logic [mar_pkg::MAG_W-1:0]       o_mag,
    output logic [mar_pkg::DEN_W-1:0]       o_den,
    output mar_pkg::t_side                  o_side
);
    import mar_pkg::*;

    logic [RI_W-1:0]  ri;
    logic             vi_range_ok;
    logic             ohm_range_ok;
    logic             v_over;
    logic             v_zero;
    logic             a_over;
    logic             a_zero;
    logic             ac_quiet;
    logic             ohm_open;
    logic [X_W-1:0]   ac_x;
    logic [X_W-1:0]   ohm_gap;

    t_side            n_a_side;
    logic [X_W-1:0]   n_a_x;
    logic             n_a_amp;
    logic             n_a_ohm;
    logic [DEN_W-1:0] n_a_den;

    logic             r_a_valid;
    t_side            r_a_side;
    logic [X_W-1:0]   r_a_x;
    logic [RI_W-1:0]  r_a_ri;
    logic             r_a_amp;
    logic             r_a_ohm;
    logic [DEN_W-1:0] r_a_den;

    logic [NUM_W-1:0] n_b_num;
    logic             r_b_valid;
    t_side            r_b_side;
    logic [NUM_W-1:0] r_b_num;
    logic [DEN_W-1:0] r_b_den;

    logic             r_c_valid;
    t_side            r_c_side;
    logic [MAG_W-1:0] r_c_mag;
    logic [DEN_W-1:0] r_c_den;

    // ---- stage A: classify the sample and pick the operand ----
    assign ri           = RI_W'(i_cfg.meter_range - RANGE_LO);
    assign vi_range_ok  = (i_cfg.meter_range >= RANGE_LO) && (i_cfg.meter_range <= RANGE_HI_VI);
    assign ohm_range_ok = (i_cfg.meter_range >= RANGE_LO) && (i_cfg.meter_range <= RANGE_HI_OHM);
    assign v_over       = (i_sample >= V_OVER_HI) || (i_sample <= V_OVER_LO);
    assign v_zero       = (i_sample >= V_ZERO_LO) && (i_sample <= V_ZERO_HI);
    assign a_over       = (i_sample >= A_OVER_HI) || (i_sample <= A_OVER_LO);
    assign a_zero       = (i_sample >= A_ZERO_LO) && (i_sample <= A_ZERO_HI);
    assign ac_quiet     = X_W'(i_total_sample) <= (X_W'(i_sample) + AC_GAP);
    assign ohm_open     = X_W'(i_sample) >= X_W'(ADC_FULL_SCALE);
    assign ac_x         = X_W'(i_total_sample) - X_W'(i_sample) + X_W'(volt_ofs(ri));
    assign ohm_gap      = X_W'(ADC_FULL_SCALE) - X_W'(i_sample);

    always_comb begin
        n_a_side = '{status: ST_OK, neg: 1'b0};
        n_a_x    = X_W'(i_sample);
        n_a_amp  = 1'b0;
        n_a_ohm  = 1'b0;
        unique case (i_cfg.quantity)
            Q_VOLT: begin
                priority if (!vi_range_ok) begin
                    n_a_side.status = ST_BAD;
                end else if (v_over) begin
                    n_a_side.status = ST_OVER;
                end else if (v_zero) begin
                    n_a_side.status = ST_ZERO;
                end else if (!i_cfg.coupling) begin
                    n_a_x = X_W'(i_sample);
                end else if (ac_quiet) begin
                    n_a_side.status = ST_ZERO;
                end else begin
                    n_a_x = ac_x;
                end
            end
            Q_AMP: begin
                n_a_amp = 1'b1;
                priority if (!vi_range_ok) begin
                    n_a_side.status = ST_BAD;
                end else if (a_over) begin
                    n_a_side.status = ST_OVER;
                end else if (a_zero) begin
                    n_a_side.status = ST_ZERO;
                end else begin
                    n_a_x = i_cfg.coupling ? X_W'(i_total_sample) : X_W'(i_sample);
                end
            end
            Q_OHM: begin
                n_a_ohm = 1'b1;
                priority if (!ohm_range_ok) begin
                    n_a_side.status = ST_BAD;
                end else if (ohm_open) begin
                    n_a_side.status = ST_OVER;
                end else begin
                    n_a_x = X_W'(i_sample);
                end
            end
            default: begin
                n_a_side.status = ST_BAD;
            end
        endcase
    end

    // slope scaled to the ADC full scale, or the divider's lower leg
    assign n_a_den = n_a_ohm ? DEN_W'(DEN_W'(CAL_SCALE) * DEN_W'(ohm_gap))
                             : DEN_W'(DEN_W'(cal_slope(n_a_amp, ri)) * DEN_W'(ADC_FULL_SCALE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side <= n_a_side;
        r_a_x    <= n_a_x;
        r_a_ri   <= ri;
        r_a_amp  <= n_a_amp;
        r_a_ohm  <= n_a_ohm;
        r_a_den  <= n_a_den;
    end

    // ---- stage B: numerator, signed ----
    assign n_b_num = r_a_ohm ? NUM_W'(NUM_W'(ohm_div(r_a_ri)) * NUM_W'(r_a_x))
                             : NUM_W'(NUM_W'(r_a_x) * NUM_W'(X_SCALE)
                                      - NUM_W'(cal_icpt(r_a_amp, r_a_ri))
                                        * NUM_W'(ADC_FULL_SCALE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_side <= r_a_side;
        r_b_num  <= n_b_num;
        r_b_den  <= r_a_den;
    end

    // ---- stage C: split into sign and magnitude ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_side.status <= r_b_side.status;
        r_c_side.neg    <= r_b_num[NUM_W-1];
        r_c_mag         <= r_b_num[NUM_W-1] ? MAG_W'(-r_b_num) : MAG_W'(r_b_num);
        r_c_den         <= r_b_den;
    end

    assign o_valid = r_c_valid;
    assign o_mag   = r_c_mag;
    assign o_den   = r_c_den;
    assign o_side  = r_c_side;

endmodule

@@ hw/rtl/mar_div.sv @@
// ----------------------------------------------------------------------------
// mar_div
// Restoring divider, one quotient bit per stage, QUO_W stages.
// ----------------------------------------------------------------------------
module mar_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [mar_pkg::MAG_W-1:0]   i_mag,
    input  logic [mar_pkg::DEN_W-1:0]   i_den,
    input  mar_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [mar_pkg::QUO_W-1:0]   o_quo,
    output mar_pkg::t_side              o_side
);
    import mar_pkg::*;

    // step inputs
    logic [DEN_W-1:0] w_rem   [QUO_W];
    logic [QUO_W-1:0] w_work  [QUO_W];
    logic [DEN_W-1:0] w_den   [QUO_W];
    t_side            w_side  [QUO_W];
    logic             w_valid [QUO_W];

    // step outputs; the last step keeps no remainder or divisor
    logic [DEN_W-1:0] r_rem   [QUO_W-1];
    logic [DEN_W-1:0] r_den   [QUO_W-1];
    logic [QUO_W-1:0] r_work  [QUO_W];
    t_side            r_side  [QUO_W];
    logic             r_valid [QUO_W];

    // The dividend is mag scaled by 2^(FRAC_BITS+1). Its bits above the
    // quotient width sit below the divisor and seed the remainder; the rest
    // shift in from the work word while quotient bits shift out the bottom.
    genvar k;
    for (k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic           take;

        if (k == 0) begin : g_load
            assign w_rem[k]   = DEN_W'(i_mag >> SHIFT_IN);
            assign w_work[k]  = {i_mag[SHIFT_IN-1:0], {(FRAC_BITS+1){1'b0}}};
            assign w_den[k]   = i_den;
            assign w_side[k]  = i_side;
            assign w_valid[k] = i_valid;
        end else begin : g_chain
            assign w_rem[k]   = r_rem[k-1];
            assign w_work[k]  = r_work[k-1];
            assign w_den[k]   = r_den[k-1];
            assign w_side[k]  = r_side[k-1];
            assign w_valid[k] = r_valid[k-1];
        end

        assign trial = {w_rem[k], w_work[k][QUO_W-1]};
        assign take  = trial >= {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_work[k] <= {w_work[k][QUO_W-2:0], take};
            r_side[k] <= w_side[k];
        end

        if (k < QUO_W - 1) begin : g_carry
            logic [DEN_W:0] diff;

            assign diff = trial - {1'b0, w_den[k]};

            always_ff @(posedge i_clk) begin
                r_rem[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_den[k] <= w_den[k];
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_work[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

@@ hw/rtl/mar_round.sv @@
// ----------------------------------------------------------------------------
// mar_round
// Round half away from zero, saturate, apply sign and status; 2 stages.
// ----------------------------------------------------------------------------
module mar_round (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [mar_pkg::QUO_W-1:0]           i_quo,
    input  mar_pkg::t_side                      i_side,
    output logic                                o_done,
    output logic signed [mar_pkg::READ_W-1:0]   o_reading,
    output logic [1:0]                          o_status
);
    import mar_pkg::*;

    logic [READ_W-1:0] n_rnd;
    logic [READ_W-1:0] n_reading;

    logic              r_rnd_valid;
    logic [READ_W-1:0] r_rnd;
    t_side             r_rnd_side;

    logic              r_done;
    logic [READ_W-1:0] r_reading;
    t_status           r_status;

    // quotient carries one extra fraction bit: add half, drop it
    assign n_rnd = READ_W'(((QUO_W+1)'(i_quo) + (QUO_W+1)'(1)) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
        end else begin
            r_rnd_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd      <= n_rnd;
        r_rnd_side <= i_side;
    end

    always_comb begin
        n_reading = '0;
        unique case (r_rnd_side.status)
            ST_OK: begin
                if (r_rnd[READ_W-1]) begin
                    n_reading = r_rnd_side.neg ? READ_MIN : READ_MAX;
                end else begin
                    n_reading = r_rnd_side.neg ? READ_W'(-r_rnd) : r_rnd;
                end
            end
            ST_OVER: n_reading = OVER_READ;
            ST_ZERO: n_reading = '0;
            ST_BAD:  n_reading = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_rnd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reading <= n_reading;
        r_status  <= r_rnd_side.status;
    end

    assign o_done    = r_done;
    assign o_reading = $signed(r_reading);
    assign o_status  = r_status;

endmodule

@@ hw/rtl/multimeter_adc_to_reading.sv @@
// ----------------------------------------------------------------------------
// multimeter_adc_to_reading
// Turns a 10-bit ADC sample (and the AC total sample) into a signed Q16.16
// meter reading for voltage, current or resistance, with status.
//
//   channel   signals                                    transfer
//   -------   ----------------------------------------   -------------------
//   request   start, busy, i_sample, i_total_sample      start && !busy
//   result    o_done, o_reading, o_status                o_done, one cycle
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index,     valid && ready
//             i_cfg_data
//
// One request per cycle while busy is low; each result passes 3 front stages,
// 32 divider stages (one quotient bit each) and 2 rounding stages. The
// 32-step divider makes up most of the pipeline depth.
// Synchronous active-low reset clears the valid bits and config; busy is high
// and cfg ready low while reset is held and until the first edge after it.
// The result side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`include "multimeter_adc_to_reading_defines.svh"

module multimeter_adc_to_reading (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request
    input  logic                                start,
    output logic                                busy,
    input  logic [mar_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [mar_pkg::SAMPLE_W-1:0]        i_total_sample,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mar_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mar_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // result
    output logic                                o_done,
    output logic signed [mar_pkg::READ_W-1:0]   o_reading,
    output logic [1:0]                          o_status
);
    import mar_pkg::*;

    logic             r_live;
    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic             req_take;
    logic             cfg_take;

    logic             front_valid;
    logic [MAG_W-1:0] front_mag;
    logic [DEN_W-1:0] front_den;
    t_side            front_side;

    logic             div_valid;
    logic [QUO_W-1:0] div_quo;
    t_side            div_side;

    logic             flat_done;
    logic             over_done;

    // Hold off requests and config writes until the first edge after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign busy        = !r_live;
    assign o_cfg_ready = r_live;
    assign req_take    = start && !busy;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;

    // Config register file; an index past the last register is dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (cfg_take) begin
            unique case (i_cfg_index)
                CFG_QUANTITY: n_cfg.quantity    = i_cfg_data[QUANT_W-1:0];
                CFG_RANGE:    n_cfg.meter_range = i_cfg_data[RANGE_W-1:0];
                CFG_COUPLING: n_cfg.coupling    = i_cfg_data[0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Classify, select operands, build numerator and denominator.
    mar_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (req_take),
        .i_sample       (i_sample),
        .i_total_sample (i_total_sample),
        .i_cfg          (r_cfg),
        .o_valid        (front_valid),
        .o_mag          (front_mag),
        .o_den          (front_den),
        .o_side         (front_side)
    );

    // Long division, status and sign carried alongside.
    mar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_mag   (front_mag),
        .i_den   (front_den),
        .i_side  (front_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // Round, saturate and substitute the fixed readings of the special cases.
    mar_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (div_valid),
        .i_quo     (div_quo),
        .i_side    (div_side),
        .o_done    (o_done),
        .o_reading (o_reading),
        .o_status  (o_status)
    );

    // ---- checks ----
    assign flat_done = o_done && (o_status == ST_BAD || o_status == ST_ZERO);
    assign over_done = o_done && (o_status == ST_OVER);

    `MAR_ASSERT_IMP(a_flat_zero, flat_done, o_reading == '0, "flat result with nonzero reading")
    `MAR_ASSERT_IMP(a_over_value, over_done, o_reading == OVER_READ, "wrong over-range value")
    `MAR_ASSERT_IMP(a_latency, o_done, $past(req_take, PIPE_LAT), "result without a request")
    `MAR_ASSERT_NEXT(a_cfg_hold, !cfg_take, r_cfg == $past(r_cfg), "config changed unwritten")

endmodule
